### sv/gcd_pkg.sv
`default_nettype none

package gcd_pkg;

  localparam int ANGLE_FRAC_BITS = 30;
  localparam int CORDIC_ITER_DEF = 28;

  // Angle, sine and cosine word: sign, two integer bits, fraction
  localparam int ANG_W   = ANGLE_FRAC_BITS + 3;
  // Microdegree operand: wide enough for a longitude difference
  localparam int UDEG_W  = 30;
  // Microdegree magnitude times the radian scale
  localparam int PROD_W  = 61;
  // Unreduced angle in radians, signed
  localparam int TH_W    = 37;
  // Square root operand (a or 1-a, four times, in 60 fraction bits) and root
  localparam int SQ_IN_W = 63;
  localparam int ROOT_W  = 32;
  // Vectoring datapath word
  localparam int VEC_W   = 36;
  localparam int DIST_W  = 25;
  localparam int IN_W    = 120;
  localparam int OUT_W   = 32;

  localparam logic [63:0] DEG_SCALE_Q56 =
      ((64'd6981317 << 40) + 64'd3051757812) / 64'd6103515625;
  localparam logic [23:0] DIAMETER_M = 24'd12742200;
  localparam logic [60:0] Q60_ONE = 61'd1 << 60;
  localparam logic [DIST_W-1:0] DIST_MAX = 25'd20016000;

  // (a*b) / 2^s, rounded
  function automatic logic [63:0] umulsh(input logic [63:0] a, input logic [63:0] b,
                                         input int unsigned s);
    logic [127:0] pr;
    pr = 128'(a) * 128'(b);
    if (s != 0) begin
      pr = pr + (128'd1 << (s - 1));
      pr = pr >> s;
    end
    return pr[63:0];
  endfunction

  // atan(2^-i), 62 fraction bits, i >= 1
  function automatic logic [63:0] atan_pow2_q62(input int unsigned i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    int unsigned k;
    p = 64'd1 << (62 - i);
    sum = 64'd0;
    for (k = 0; k < 40; k++) begin
      if (p != 64'd0) begin
        t = p / 64'(2 * k + 1);
        sum = k[0] ? sum - t : sum + t;
        p = (2 * i < 63) ? p >> (2 * i) : 64'd0;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] quarter_pi_q62();
    logic [63:0] p;
    logic [63:0] third;
    logic [63:0] t;
    int unsigned k;
    p = (64'd1 << 62) / 64'd3;
    third = 64'd0;
    for (k = 0; k < 40; k++) begin
      if (p != 64'd0) begin
        t = p / 64'(2 * k + 1);
        third = k[0] ? third - t : third + t;
        p = p / 64'd9;
      end
    end
    return atan_pow2_q62(1) + third;
  endfunction

  function automatic logic [63:0] pi_q_calc();
    return (quarter_pi_q62() + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
  endfunction

  function automatic logic [63:0] step_angle(input int unsigned i);
    logic [63:0] t;
    t = (i == 0) ? quarter_pi_q62() : atan_pow2_q62(i);
    return (t + (64'd1 << (61 - ANGLE_FRAC_BITS))) >> (62 - ANGLE_FRAC_BITS);
  endfunction

  // Inverse CORDIC gain for n steps, Newton on 1/sqrt(g)
  function automatic logic [63:0] gain_q(input int unsigned n);
    logic [63:0] g;
    logic [63:0] y;
    logic [63:0] gyy;
    int unsigned i;
    g = 64'd1 << 60;
    for (i = 0; i < 64; i++) begin
      if (i < n && 2 * i < 64) begin
        g = g + (g >> (2 * i));
      end
    end
    y = (64'd3 << 60) / 64'd5;
    for (i = 0; i < 12; i++) begin
      gyy = umulsh(g, umulsh(y, y, 60), 60);
      if (gyy > (64'd3 << 60)) begin
        gyy = 64'd3 << 60;
      end
      y = umulsh(y, (64'd3 << 60) - gyy, 61);
    end
    return (y + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
  endfunction

  localparam logic [63:0] PI_Q64 = pi_q_calc();

endpackage

`default_nettype wire

### sv/gcd_sincos.sv
`default_nettype none

module gcd_sincos #(
  parameter int ITER = gcd_pkg::CORDIC_ITER_DEF,
  parameter bit DIFF = 1'b0
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  wire logic                               in_valid,
  input  wire logic signed [gcd_pkg::UDEG_W-1:0]  in_udeg,
  output logic                                    out_valid,
  output logic signed [gcd_pkg::ANG_W-1:0]        out_val
);
  import gcd_pkg::*;

  // DIFF: halve the angle and give its sine; otherwise give the cosine
  localparam int SH = 56 - ANGLE_FRAC_BITS + (DIFF ? 1 : 0);
  localparam logic signed [TH_W-1:0] PI_T      = TH_W'(PI_Q64);
  localparam logic signed [TH_W-1:0] HALF_PI_T = TH_W'(PI_Q64 >> 1);
  localparam logic signed [TH_W-1:0] TWO_PI_T  = TH_W'(PI_Q64 << 1);
  localparam logic signed [ANG_W-1:0] GAIN     = ANG_W'(gain_q(ITER));

  logic [UDEG_W-1:0] mag;
  logic [PROD_W-1:0] prod_r;
  logic              neg_r;
  logic              va_r;

  assign mag = in_udeg[UDEG_W-1] ? UDEG_W'(-in_udeg) : UDEG_W'(in_udeg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= mag * DEG_SCALE_Q56[30:0];
      neg_r  <= in_udeg[UDEG_W-1];
    end
  end

  // Round to radians, then wrap to [-pi, pi] and fold into [-pi/2, pi/2].
  // The magnitude of any input stays below 3*pi, so one wrap step does.
  logic [PROD_W-1:0]        rnd;
  logic [PROD_W-1:0]        shv;
  logic signed [TH_W-1:0]   th;
  logic signed [TH_W-1:0]   wr;
  logic signed [TH_W-1:0]   fold_nxt;
  logic                     flip_nxt;

  always_comb begin
    rnd = prod_r + (PROD_W'(1) << (SH - 1));
    shv = rnd >> SH;
    th  = {1'b0, shv[TH_W-2:0]};
    if (neg_r) begin
      th = -th;
    end
    if (th > PI_T) begin
      wr = th - TWO_PI_T;
    end else if (th < -PI_T) begin
      wr = th + TWO_PI_T;
    end else begin
      wr = th;
    end
    if (wr > HALF_PI_T) begin
      fold_nxt = PI_T - wr;
      flip_nxt = 1'b1;
    end else if (wr < -HALF_PI_T) begin
      fold_nxt = -PI_T - wr;
      flip_nxt = 1'b1;
    end else begin
      fold_nxt = wr;
      flip_nxt = 1'b0;
    end
  end

  logic signed [ANG_W-1:0] x_r    [ITER+1];
  logic signed [ANG_W-1:0] y_r    [ITER+1];
  logic signed [ANG_W-1:0] z_r    [ITER+1];
  logic                    flip_r [ITER+1];
  logic                    v_r    [ITER+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= ANG_W'(fold_nxt);
      flip_r[0] <= flip_nxt;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_it
    localparam logic signed [ANG_W-1:0] ANG = ANG_W'(step_angle(i));
    logic signed [ANG_W-1:0] dx;
    logic signed [ANG_W-1:0] dy;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][ANG_W-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - ANG;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + ANG;
        end
        flip_r[i+1] <= flip_r[i];
      end
    end
  end

  assign out_valid = v_r[ITER];
  assign out_val   = DIFF ? y_r[ITER] : (flip_r[ITER] ? -x_r[ITER] : x_r[ITER]);

endmodule

`default_nettype wire

### sv/gcd_isqrt.sv
`default_nettype none

module gcd_isqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [gcd_pkg::SQ_IN_W-1:0]  in_n,
  output logic                              out_valid,
  output logic [gcd_pkg::ROOT_W-1:0]        out_root
);
  import gcd_pkg::*;

  localparam int TW = SQ_IN_W + 3;

  logic [SQ_IN_W-1:0] rem_r  [1:ROOT_W];
  logic [ROOT_W-1:0]  root_r [1:ROOT_W];
  logic               v_r    [1:ROOT_W];

  // One result bit per stage, most significant first
  for (genvar k = 0; k < ROOT_W; k++) begin : g_st
    localparam int B = ROOT_W - 1 - k;
    logic [SQ_IN_W-1:0] rem_in;
    logic [ROOT_W-1:0]  root_in;
    logic               v_in;
    logic [TW-1:0]      t;

    if (k == 0) begin : g_first
      assign rem_in  = in_n;
      assign root_in = '0;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k];
      assign root_in = root_r[k];
      assign v_in    = v_r[k];
    end

    // (root + 2^B)^2 - root^2
    assign t = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (TW'(rem_in) >= t) begin
          rem_r[k+1]  <= rem_in - t[SQ_IN_W-1:0];
          root_r[k+1] <= root_in | (ROOT_W'(1) << B);
        end else begin
          rem_r[k+1]  <= rem_in;
          root_r[k+1] <= root_in;
        end
      end
    end
  end

  assign out_valid = v_r[ROOT_W];
  assign out_root  = root_r[ROOT_W];

endmodule

`default_nettype wire

### sv/gcd_vector.sv
`default_nettype none

module gcd_vector #(
  parameter int ITER = gcd_pkg::CORDIC_ITER_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [gcd_pkg::ROOT_W-1:0]  in_u,
  input  wire logic [gcd_pkg::ROOT_W-1:0]  in_v,
  output logic                             out_valid,
  output logic signed [gcd_pkg::ANG_W-1:0] out_z
);
  import gcd_pkg::*;

  logic signed [VEC_W-1:0] x_r [1:ITER];
  logic signed [VEC_W-1:0] y_r [1:ITER];
  logic signed [ANG_W-1:0] z_r [1:ITER];
  logic                    v_r [1:ITER];

  // Rotate (v, u) onto the x axis; z collects atan2(u, v)
  for (genvar i = 0; i < ITER; i++) begin : g_it
    localparam logic signed [ANG_W-1:0] ANG = ANG_W'(step_angle(i));
    logic signed [VEC_W-1:0] x_in;
    logic signed [VEC_W-1:0] y_in;
    logic signed [ANG_W-1:0] z_in;
    logic                    v_in;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;

    if (i == 0) begin : g_first
      assign x_in = VEC_W'(in_v);
      assign y_in = VEC_W'(in_u);
      assign z_in = '0;
      assign v_in = in_valid;
    end else begin : g_next
      assign x_in = x_r[i];
      assign y_in = y_r[i];
      assign z_in = z_r[i];
      assign v_in = v_r[i];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_in[VEC_W-1] && y_in != '0) begin
          x_r[i+1] <= x_in + dx;
          y_r[i+1] <= y_in - dy;
          z_r[i+1] <= z_in + ANG;
        end else begin
          x_r[i+1] <= x_in - dx;
          y_r[i+1] <= y_in + dy;
          z_r[i+1] <= z_in - ANG;
        end
      end
    end
  end

  assign out_valid = v_r[ITER];
  assign out_z     = z_r[ITER];

endmodule

`default_nettype wire

### sv/great_circle_distance.sv
// Haversine distance between two points given in signed microdegrees.
// The delay through the block is set by the two CORDIC pipelines and the
// 32-stage square root pipeline.
// Throughput: one transfer per cycle; the whole pipeline holds while a result
// waits on out_tready. Synchronous active-low reset clears all valid bits.
`default_nettype none

module great_circle_distance #(
  parameter int CORDIC_ITERATIONS = gcd_pkg::CORDIC_ITER_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // first_latitude, first_longitude, second_latitude, second_longitude
  input  wire logic [gcd_pkg::IN_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // distance_metres
  output logic [gcd_pkg::OUT_W-1:0]       out_tdata
);
  import gcd_pkg::*;

  logic en;
  logic out_valid_r;
  logic [DIST_W-1:0] dist_r;

  assign en         = out_tready || !out_valid_r;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W - DIST_W)'(0), dist_r};

  logic signed [27:0] lat1;
  logic signed [28:0] lon1;
  logic signed [27:0] lat2;
  logic signed [28:0] lon2;
  logic signed [UDEG_W-1:0] dlat;
  logic signed [UDEG_W-1:0] dlon;

  assign lat1 = in_tdata[27:0];
  assign lon1 = in_tdata[56:28];
  assign lat2 = in_tdata[84:57];
  assign lon2 = in_tdata[113:85];
  assign dlat = UDEG_W'(lat2) - UDEG_W'(lat1);
  assign dlon = UDEG_W'(lon2) - UDEG_W'(lon1);

  logic                    sc_valid;
  logic signed [ANG_W-1:0] s_lat;
  logic signed [ANG_W-1:0] s_lon;
  logic signed [ANG_W-1:0] c_a;
  logic signed [ANG_W-1:0] c_b;

  gcd_sincos #(.ITER(CORDIC_ITERATIONS), .DIFF(1'b1)) u_sin_lat (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid), .in_udeg(dlat),
    .out_valid(sc_valid), .out_val(s_lat)
  );
  gcd_sincos #(.ITER(CORDIC_ITERATIONS), .DIFF(1'b1)) u_sin_lon (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid), .in_udeg(dlon),
    .out_valid(), .out_val(s_lon)
  );
  gcd_sincos #(.ITER(CORDIC_ITERATIONS), .DIFF(1'b0)) u_cos_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid), .in_udeg(UDEG_W'(lat1)),
    .out_valid(), .out_val(c_a)
  );
  gcd_sincos #(.ITER(CORDIC_ITERATIONS), .DIFF(1'b0)) u_cos_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_tvalid), .in_udeg(UDEG_W'(lat2)),
    .out_valid(), .out_val(c_b)
  );

  // Squares and the cosine product
  logic [ANG_W-2:0] m_slat, m_slon, m_ca, m_cb;
  assign m_slat = s_lat[ANG_W-1] ? (ANG_W-1)'(-s_lat) : (ANG_W-1)'(s_lat);
  assign m_slon = s_lon[ANG_W-1] ? (ANG_W-1)'(-s_lon) : (ANG_W-1)'(s_lon);
  assign m_ca   = c_a[ANG_W-1] ? (ANG_W-1)'(-c_a) : (ANG_W-1)'(c_a);
  assign m_cb   = c_b[ANG_W-1] ? (ANG_W-1)'(-c_b) : (ANG_W-1)'(c_b);

  logic        p1_v_r, p2_v_r, p3_v_r, p4_v_r, p5_v_r;
  logic [63:0] p1_sl2_r, p1_slo2_r, p1_cc_r;
  logic        p1_neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_sl2_r  <= m_slat * m_slat;
      p1_slo2_r <= m_slon * m_slon;
      p1_cc_r   <= m_ca * m_cb;
      p1_neg_r  <= c_a[ANG_W-1] ^ c_b[ANG_W-1];
    end
  end

  // Cosine product back to angle format, rounded
  logic [63:0] cc_sum;
  logic [63:0] cc_shift;
  assign cc_sum   = p1_cc_r + (64'd1 << (ANGLE_FRAC_BITS - 1));
  assign cc_shift = cc_sum >> ANGLE_FRAC_BITS;

  logic [63:0]       p2_sl2_r, p2_slo2_r;
  logic [ROOT_W-1:0] p2_cc_r;
  logic              p2_neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_sl2_r  <= p1_sl2_r;
      p2_slo2_r <= p1_slo2_r;
      p2_cc_r   <= cc_shift[ROOT_W-1:0];
      p2_neg_r  <= p1_neg_r;
    end
  end

  // Split the wide product into two partial products
  logic [63:0] p3_sl2_r;
  logic [62:0] p3_lo_r;
  logic [64:0] p3_hi_r;
  logic        p3_neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_sl2_r <= p2_sl2_r;
      p3_lo_r  <= p2_slo2_r[30:0] * p2_cc_r;
      p3_hi_r  <= p2_slo2_r[63:31] * p2_cc_r;
      p3_neg_r <= p2_neg_r;
    end
  end

  logic [95:0] term_sum;
  logic [95:0] term_shift;
  assign term_sum   = (96'(p3_hi_r) << 31) + 96'(p3_lo_r) + (96'd1 << (ANGLE_FRAC_BITS - 1));
  assign term_shift = term_sum >> ANGLE_FRAC_BITS;

  logic [63:0] p4_sl2_r;
  logic [63:0] p4_term_r;
  logic        p4_neg_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p4_sl2_r  <= p3_sl2_r;
      p4_term_r <= term_shift[63:0];
      p4_neg_r  <= p3_neg_r;
    end
  end

  // a = sin^2(dlat/2) + sin^2(dlon/2) cos cos, held to [0, 1]
  logic signed [65:0] a_sum;
  logic [60:0]        a_sat;

  always_comb begin
    if (p4_neg_r) begin
      a_sum = $signed({2'b00, p4_sl2_r}) - $signed({2'b00, p4_term_r});
    end else begin
      a_sum = $signed({2'b00, p4_sl2_r}) + $signed({2'b00, p4_term_r});
    end
    if (a_sum[65]) begin
      a_sat = '0;
    end else if (a_sum > $signed(66'(Q60_ONE))) begin
      a_sat = Q60_ONE;
    end else begin
      a_sat = a_sum[60:0];
    end
  end

  logic [SQ_IN_W-1:0] p5_n1_r, p5_n2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_n1_r <= {a_sat, 2'b00};
      p5_n2_r <= {Q60_ONE - a_sat, 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
      p5_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= sc_valid;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
      p5_v_r <= p4_v_r;
    end
  end

  logic              sq_valid;
  logic [ROOT_W-1:0] root_u, root_v;

  gcd_isqrt u_sqrt_a (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(p5_v_r), .in_n(p5_n1_r),
    .out_valid(sq_valid), .out_root(root_u)
  );
  gcd_isqrt u_sqrt_b (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(p5_v_r), .in_n(p5_n2_r),
    .out_valid(), .out_root(root_v)
  );

  logic                    vec_valid;
  logic signed [ANG_W-1:0] z_ang;

  gcd_vector #(.ITER(CORDIC_ITERATIONS)) u_atan (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(sq_valid), .in_u(root_u), .in_v(root_v),
    .out_valid(vec_valid), .out_z(z_ang)
  );

  // Drop a small negative residual angle, then scale by the diameter
  logic [ANG_W-2:0] z_pos;
  assign z_pos = z_ang[ANG_W-1] ? '0 : z_ang[ANG_W-2:0];

  logic        f1_v_r;
  logic [55:0] f1_prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      f1_prod_r <= z_pos * DIAMETER_M;
    end
  end

  logic [55:0] d_sum;
  logic [55:0] d_shift;
  assign d_sum   = f1_prod_r + (56'd1 << (ANGLE_FRAC_BITS - 1));
  assign d_shift = d_sum >> ANGLE_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= d_shift[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      f1_v_r      <= vec_valid;
      out_valid_r <= f1_v_r;
    end
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  a_distance_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> out_tdata[DIST_W-1:0] <= DIST_MAX)
    else $error("distance beyond half circumference");
`endif

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import gcd_pkg::*;

  localparam int STEPS = CORDIC_ITER_DEF;
  localparam int FRAC = ANGLE_FRAC_BITS;
  localparam int STALL_LIMIT = 5000;
  localparam int PIPE_DEPTH = 2 * STEPS + 41;
  localparam longint unsigned UNIT_Q60 = 64'd1 << 60;
  localparam longint unsigned EARTH_DIAMETER_M = 64'd12742200;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;

  logic [DIST_W-1:0] expected_distance[$];
  int mismatch_count = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  longint step_rad[STEPS];
  longint pi_rad;
  longint cordic_gain;

  great_circle_distance uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // 128-bit product shifted right by s with rounding, low 64 bits kept
  function automatic longint unsigned mul_round(longint unsigned a, longint unsigned b, int s);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (s != 0) begin
      p = (p + (128'd1 << (s - 1))) >> s;
    end
    return p[63:0];
  endfunction

  function automatic longint mul_signed(longint a, longint b, int s);
    longint unsigned ua;
    longint unsigned ub;
    longint r;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    r = mul_round(ua, ub, s);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint unsigned atan_series(int i);
    longint unsigned p;
    longint unsigned sum;
    longint unsigned k;
    p = 64'd1 << (62 - i);
    sum = 0;
    k = 0;
    while (p != 0) begin
      sum = k[0] ? sum - p / (2 * k + 1) : sum + p / (2 * k + 1);
      p = (2 * i < 63) ? p >> (2 * i) : 64'd0;
      k++;
    end
    return sum;
  endfunction

  task automatic build_constants();
    longint unsigned p;
    longint unsigned third;
    longint unsigned k;
    longint unsigned qpi;
    longint unsigned g;
    longint unsigned y;
    longint unsigned gyy;
    longint unsigned t;
    p = (64'd1 << 62) / 3;
    third = 0;
    k = 0;
    while (p != 0) begin
      third = k[0] ? third - p / (2 * k + 1) : third + p / (2 * k + 1);
      p = p / 9;
      k++;
    end
    qpi = atan_series(1) + third;
    pi_rad = (qpi + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
    g = UNIT_Q60;
    for (int i = 0; i < STEPS; i++) begin
      t = (i == 0) ? qpi : atan_series(i);
      step_rad[i] = (t + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
      if (2 * i < 64) g = g + (g >> (2 * i));
    end
    y = (64'd3 << 60) / 5;
    for (int n = 0; n < 12; n++) begin
      gyy = mul_round(g, mul_round(y, y, 60), 60);
      if (gyy > (64'd3 << 60)) gyy = 64'd3 << 60;
      y = mul_round(y, (64'd3 << 60) - gyy, 61);
    end
    cordic_gain = (y + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
  endtask

  function automatic longint udeg_to_rad(longint udeg, int halve);
    int sh;
    longint unsigned m;
    longint r;
    sh = 56 - FRAC + halve;
    m = (udeg < 0) ? -udeg : udeg;
    r = (m * DEG_SCALE_Q56 + (64'd1 << (sh - 1))) >> sh;
    return (udeg < 0) ? -r : r;
  endfunction

  function automatic void rotate(longint th, output longint s, output longint c);
    longint r;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit flip;
    r = th % (2 * pi_rad);
    x = cordic_gain;
    y = 0;
    flip = 0;
    if (r > pi_rad) r -= 2 * pi_rad;
    else if (r < -pi_rad) r += 2 * pi_rad;
    // fold into the right half plane, cosine changes sign
    if (r > pi_rad / 2) begin
      r = pi_rad - r;
      flip = 1;
    end else if (r < -(pi_rad / 2)) begin
      r = -pi_rad - r;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (r >= 0) begin
        x -= dx; y += dy; r -= step_rad[i];
      end else begin
        x += dx; y -= dy; r += step_rad[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [DIST_W-1:0] haversine_metres(longint la1, longint lo1,
                                                         longint la2, longint lo2);
    longint s_lat;
    longint s_lon;
    longint c1;
    longint c2;
    longint unused;
    longint a;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint unsigned d;
    rotate(udeg_to_rad(la2 - la1, 1), s_lat, unused);
    rotate(udeg_to_rad(lo2 - lo1, 1), s_lon, unused);
    rotate(udeg_to_rad(la1, 0), unused, c1);
    rotate(udeg_to_rad(la2, 0), unused, c2);
    a = mul_signed(s_lat, s_lat, 2 * FRAC - 60)
      + mul_signed(mul_signed(s_lon, s_lon, 2 * FRAC - 60), mul_signed(c1, c2, FRAC), FRAC);
    if (a < 0) a = 0;
    if (a > longint'(UNIT_Q60)) a = UNIT_Q60;
    x = root64((UNIT_Q60 - a) << 2);
    y = root64(longint'(a) << 2);
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += step_rad[i];
      end else begin
        x -= dx; y += dy; z -= step_rad[i];
      end
    end
    if (z < 0) z = 0;
    d = mul_round(z, EARTH_DIAMETER_M, FRAC);
    return d[DIST_W-1:0];
  endfunction

  task automatic report_mismatch(logic [DIST_W-1:0] got, logic [DIST_W-1:0] want);
    $display("distance_metres mismatch: got %0d expected %0d at %0t", got, want, $realtime);
    mismatch_count++;
  endtask

  // Send one point pair, holding it until the transfer completes
  task automatic send_pair(int la1, int lo1, int la2, int lo2);
    logic signed [27:0] f_la1;
    logic signed [28:0] f_lo1;
    logic signed [27:0] f_la2;
    logic signed [28:0] f_lo2;
    f_la1 = 28'(la1);
    f_lo1 = 29'(lo1);
    f_la2 = 28'(la2);
    f_lo2 = 29'(lo2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, f_lo2, f_la2, f_lo1, f_la1};
    do @(posedge clk); while (!in_tready);
    expected_distance.push_back(haversine_metres(f_la1, f_lo1, f_la2, f_lo2));
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_distance.size() != 0) @(posedge clk);
  endtask

  task automatic test_corner_points();
    send_pair(0, 0, 0, 0);
    send_pair(45000000, 90000000, 45000000, 90000000);
    send_pair(0, 0, 0, 180000000);
    send_pair(0, -180000000, 0, 180000000);
    send_pair(90000000, 0, -90000000, 0);
    send_pair(90000000, 12345678, 90000000, -98765432);
    send_pair(-90000000, -180000000, 90000000, 180000000);
    send_pair(0, 179999999, 0, -179999999);
    send_pair(51477000, 0, 40712800, -74006000);
    send_pair(10, 10, 11, 11);
    send_pair(1, 0, 0, 0);
    send_pair(-33868800, 151209300, 35676200, 139650300);
    send_pair(45000000, 0, -45000000, 180000000);
    // bit patterns beyond the valid ranges: angles wrap, cosine goes negative
    send_pair(-28'sd134217728, -29'sd268435456, 28'sd134217727, 29'sd268435455);
    send_pair(28'sd134217727, 29'sd268435455, -28'sd134217728, -29'sd268435456);
    send_pair(120000000, 0, 120000000, 90000000);
    send_pair(-134217728, 0, 134217727, 0);
    send_pair(100000000, 200000000, -100000000, -200000000);
    send_pair(0, 0, 0, 1);
    send_pair(89999999, 0, -89999999, 180000000);
    // hold off until the pipeline is empty
    wait_drain();
  endtask

  task automatic test_random_pairs(int count, int s_idle, int r_idle);
    int la1;
    int lo1;
    int la2;
    int lo2;
    int kind;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(99);
      la1 = int'($urandom_range(180000000)) - 90000000;
      lo1 = int'($urandom_range(360000000)) - 180000000;
      if (kind < 60) begin
        la2 = int'($urandom_range(180000000)) - 90000000;
        lo2 = int'($urandom_range(360000000)) - 180000000;
      end else if (kind < 80) begin
        // nearby points, tiny a
        la2 = la1 + int'($urandom_range(2000)) - 1000;
        lo2 = lo1 + int'($urandom_range(2000)) - 1000;
      end else if (kind < 90) begin
        // near antipodal points, a close to one
        la2 = -la1 + int'($urandom_range(2000)) - 1000;
        lo2 = lo1 + ((lo1 < 0) ? 180000000 : -180000000) + int'($urandom_range(2000)) - 1000;
      end else begin
        la1 = $urandom;
        lo1 = $urandom;
        la2 = $urandom;
        lo2 = $urandom;
      end
      send_pair(la1, lo1, la2, lo2);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_distance.size() == 0) begin
        $display("unexpected result %0d at %0t", out_tdata[DIST_W-1:0], $realtime);
        mismatch_count++;
      end else if (out_tdata[DIST_W-1:0] !== expected_distance[0]) begin
        report_mismatch(out_tdata[DIST_W-1:0], expected_distance.pop_front());
      end else begin
        void'(expected_distance.pop_front());
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    build_constants();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_corner_points();
    test_random_pairs(560, 7, 73);
    test_random_pairs(560, 73, 7);
    test_random_pairs(560, 0, 0);
    wait_drain();
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (mismatch_count == 0 && expected_distance.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
